@@ rtl/ihex_pkg.sv @@
// Intel HEX parser package: parse phase codes, base mode codes, result word type
// and the ASCII hex digit decoder. No dependencies.
package ihex_pkg;

    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_ADDR = 3'd2;
    localparam logic [2:0] PH_TYPE = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CSUM = 3'd5;

    localparam logic [1:0] BASE_NONE    = 2'd0;
    localparam logic [1:0] BASE_LINEAR  = 2'd1;
    localparam logic [1:0] BASE_SEGMENT = 2'd2;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_SEGMENT = 8'h02;
    localparam logic [7:0] REC_LINEAR  = 8'h04;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_address;
        logic [7:0]  write_byte;
        logic        record_done;
        logic [7:0]  record_kind;
        logic        checksum_bad;
        logic        end_of_file;
    } ihex_result_t;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            d = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return d;
    endfunction

endpackage

@@ rtl/ihex_char_if.sv @@
// Character channel: valid/ready handshake carrying one ASCII character per word.
// No dependencies.
interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

@@ rtl/ihex_result_if.sv @@
// Result channel: valid/ready handshake carrying one memory write or record status word.
// No dependencies.
interface ihex_result_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_byte;
    logic        record_done;
    logic [7:0]  record_kind;
    logic        checksum_bad;
    logic        end_of_file;

    modport source (
        output valid, output write_valid, output write_address, output write_byte,
        output record_done, output record_kind, output checksum_bad, output end_of_file,
        input ready
    );
    modport sink (
        input valid, input write_valid, input write_address, input write_byte,
        input record_done, input record_kind, input checksum_bad, input end_of_file,
        output ready
    );
endinterface

@@ rtl/ihex_out_stage.sv @@
// Result register of the Intel HEX parser: holds one result word until the sink takes it.
// Depends on ihex_pkg and ihex_result_if.
module ihex_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ihex_pkg::ihex_result_t data,
    output logic                 free,
    ihex_result_if.source        results
);

    logic                  valid_reg;
    ihex_pkg::ihex_result_t data_reg;

    assign free = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && free)
        begin
            data_reg <= data;
        end
    end

    assign results.valid         = valid_reg;
    assign results.write_valid   = data_reg.write_valid;
    assign results.write_address = data_reg.write_address;
    assign results.write_byte    = data_reg.write_byte;
    assign results.record_done   = data_reg.record_done;
    assign results.record_kind   = data_reg.record_kind;
    assign results.checksum_bad  = data_reg.checksum_bad;
    assign results.end_of_file   = data_reg.end_of_file;

endmodule

@@ rtl/intel_hex_record_parser_core.sv @@
// Intel HEX record parser top level: character register, record decoder, result register.
// Depends on ihex_pkg, ihex_char_if, ihex_result_if and ihex_out_stage.
//
// Takes one ASCII character per word and sustains one word per clock cycle while
// the result path does not stall. A character is held in the character register,
// decoded between the character register and the result register, and its result
// is registered in the result register. Each data byte of a type-0 record yields a
// write word; each checksum byte yields a status word; a type-1 record ends
// parsing until reset. Input stalls only while a result word is pending and
// the sink holds off.
module intel_hex_record_parser_core (
    input  logic          clk,
    input  logic          rst_n,
    ihex_char_if.sink     chars,
    ihex_result_if.source results
);

    logic        s0_valid_reg;
    logic [7:0]  s0_char_reg;

    logic [2:0]  phase_reg,        phase_next;
    logic [2:0]  nibble_count_reg, nibble_count_next;
    logic [15:0] partial_reg,      partial_next;
    logic [7:0]  bytes_left_reg,   bytes_left_next;
    logic [15:0] offset_reg,       offset_next;
    logic [7:0]  rec_type_reg,     rec_type_next;
    logic [7:0]  sum_reg,          sum_next;
    logic [7:0]  index_reg,        index_next;
    logic [15:0] first_two_reg,    first_two_next;
    logic [1:0]  base_mode_reg,    base_mode_next;
    logic [15:0] segment_reg,      segment_next;
    logic [15:0] linear_reg,       linear_next;
    logic        finished_reg,     finished_next;

    logic [15:0] pv_shift;
    logic [2:0]  nc_inc;
    logic [7:0]  b;
    logic [31:0] base;
    logic        res_has;
    logic        out_free;
    logic        s0_adv;
    logic        s0_step;
    logic        res_push;
    ihex_pkg::ihex_result_t res;

    assign pv_shift = {partial_reg[11:0], ihex_pkg::hex_digit(s0_char_reg)};
    assign nc_inc   = nibble_count_reg + 3'd1;
    assign b        = pv_shift[7:0];

    always_comb
    begin
        unique case (base_mode_reg)
            ihex_pkg::BASE_LINEAR:  base = {linear_reg, 16'd0};
            ihex_pkg::BASE_SEGMENT: base = {12'd0, segment_reg, 4'd0};
            default:                base = 32'd0;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        nibble_count_next = nibble_count_reg;
        partial_next      = partial_reg;
        bytes_left_next   = bytes_left_reg;
        offset_next       = offset_reg;
        rec_type_next     = rec_type_reg;
        sum_next          = sum_reg;
        index_next        = index_reg;
        first_two_next    = first_two_reg;
        base_mode_next    = base_mode_reg;
        segment_next      = segment_reg;
        linear_next       = linear_reg;
        finished_next     = finished_reg;
        res               = '0;
        res_has           = 1'b0;

        if (!finished_reg)
        begin
            if (phase_reg == ihex_pkg::PH_WAIT || phase_reg > ihex_pkg::PH_CSUM)
            begin
                phase_next = ihex_pkg::PH_WAIT;
                if (s0_char_reg == ihex_pkg::CHAR_COLON)
                begin
                    sum_next          = 8'd0;
                    index_next        = 8'd0;
                    first_two_next    = 16'd0;
                    bytes_left_next   = 8'd0;
                    phase_next        = ihex_pkg::PH_LEN;
                    nibble_count_next = 3'd0;
                    partial_next      = 16'd0;
                end
            end
            else
            begin
                partial_next      = pv_shift;
                nibble_count_next = nc_inc;
                unique case (phase_reg)
                    ihex_pkg::PH_LEN:
                    begin
                        if (nc_inc == 3'd2)
                        begin
                            bytes_left_next   = b;
                            sum_next          = sum_reg + b;
                            phase_next        = ihex_pkg::PH_ADDR;
                            nibble_count_next = 3'd0;
                            partial_next      = 16'd0;
                        end
                    end
                    ihex_pkg::PH_ADDR:
                    begin
                        if (nc_inc == 3'd4)
                        begin
                            offset_next       = pv_shift;
                            sum_next          = sum_reg + b + pv_shift[15:8];
                            phase_next        = ihex_pkg::PH_TYPE;
                            nibble_count_next = 3'd0;
                            partial_next      = 16'd0;
                        end
                    end
                    ihex_pkg::PH_TYPE:
                    begin
                        if (nc_inc == 3'd2)
                        begin
                            rec_type_next     = b;
                            sum_next          = sum_reg + b;
                            phase_next        = (bytes_left_reg != 8'd0) ? ihex_pkg::PH_DATA
                                                                         : ihex_pkg::PH_CSUM;
                            nibble_count_next = 3'd0;
                            partial_next      = 16'd0;
                        end
                    end
                    ihex_pkg::PH_DATA:
                    begin
                        if (nc_inc == 3'd2)
                        begin
                            sum_next = sum_reg + b;
                            if (index_reg == 8'd0)
                            begin
                                first_two_next[15:8] = first_two_reg[15:8] | b;
                            end
                            else if (index_reg == 8'd1)
                            begin
                                first_two_next[7:0] = first_two_reg[7:0] | b;
                            end
                            if (rec_type_reg == ihex_pkg::REC_DATA)
                            begin
                                res.write_valid   = 1'b1;
                                res.write_address = base + {16'd0, offset_reg}
                                                    + {24'd0, index_reg};
                                res.write_byte    = b;
                                res_has           = 1'b1;
                            end
                            index_next        = index_reg + 8'd1;
                            bytes_left_next   = bytes_left_reg - 8'd1;
                            phase_next        = (bytes_left_reg == 8'd1) ? ihex_pkg::PH_CSUM
                                                                         : ihex_pkg::PH_DATA;
                            nibble_count_next = 3'd0;
                            partial_next      = 16'd0;
                        end
                    end
                    default:
                    begin
                        if (nc_inc == 3'd2)
                        begin
                            phase_next        = ihex_pkg::PH_WAIT;
                            nibble_count_next = 3'd0;
                            partial_next      = 16'd0;
                            res.record_done   = 1'b1;
                            res.record_kind   = rec_type_reg;
                            res_has           = 1'b1;
                            if (rec_type_reg == ihex_pkg::REC_EOF)
                            begin
                                finished_next   = 1'b1;
                                res.end_of_file = 1'b1;
                            end
                            else
                            begin
                                res.checksum_bad = ((8'd0 - sum_reg) != b);
                                if (rec_type_reg == ihex_pkg::REC_SEGMENT)
                                begin
                                    base_mode_next = ihex_pkg::BASE_SEGMENT;
                                    segment_next   = first_two_reg;
                                end
                                else if (rec_type_reg == ihex_pkg::REC_LINEAR)
                                begin
                                    base_mode_next = ihex_pkg::BASE_LINEAR;
                                    linear_next    = first_two_reg;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign s0_adv      = !res_has || out_free;
    assign s0_step     = s0_valid_reg && s0_adv;
    assign res_push    = s0_step && res_has;
    assign chars.ready = !s0_valid_reg || s0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            s0_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s0_char_reg <= chars.character;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ihex_pkg::PH_WAIT;
            nibble_count_reg <= 3'd0;
            partial_reg      <= 16'd0;
            bytes_left_reg   <= 8'd0;
            offset_reg       <= 16'd0;
            rec_type_reg     <= 8'd0;
            sum_reg          <= 8'd0;
            index_reg        <= 8'd0;
            first_two_reg    <= 16'd0;
            base_mode_reg    <= ihex_pkg::BASE_NONE;
            segment_reg      <= 16'd0;
            linear_reg       <= 16'd0;
            finished_reg     <= 1'b0;
        end
        else if (s0_step)
        begin
            phase_reg        <= phase_next;
            nibble_count_reg <= nibble_count_next;
            partial_reg      <= partial_next;
            bytes_left_reg   <= bytes_left_next;
            offset_reg       <= offset_next;
            rec_type_reg     <= rec_type_next;
            sum_reg          <= sum_next;
            index_reg        <= index_next;
            first_two_reg    <= first_two_next;
            base_mode_reg    <= base_mode_next;
            segment_reg      <= segment_next;
            linear_reg       <= linear_next;
            finished_reg     <= finished_next;
        end
    end

    ihex_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .data    (res),
        .free    (out_free),
        .results (results)
    );

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("end-of-file state cleared without reset");

    a_no_result_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !res_push)
        else $error("result produced after end of file");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res.write_valid != res.record_done))
        else $error("result word is neither or both of write and status");

    a_nibble_range: assert property (@(posedge clk) disable iff (!rst_n)
        nibble_count_reg <= 3'd3)
        else $error("nibble count out of range");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && !s0_adv) |=> $stable(phase_reg) && $stable(sum_reg))
        else $error("parser state moved while result path stalled");

endmodule
